// File: rtl/core/two_sat_propagation_solver_macros.svh
// Assertion helpers for the 2-SAT solver
`ifndef TWO_SAT_PROPAGATION_SOLVER_MACROS_SVH
`define TWO_SAT_PROPAGATION_SOLVER_MACROS_SVH
`define TSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tsp check failed");
`define TSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tsp check failed");
`endif

// File: rtl/core/tsp_pkg.sv
package tsp_pkg;
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_SOLVE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WIPE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_MCLR,
        ST_VAR,
        ST_VAR_RD,
        ST_ROOT,
        ST_TOP_RD,
        ST_ROW_RD,
        ST_ROW_SCAN,
        ST_CHK_RD,
        ST_CHK,
        ST_UNDO_RD,
        ST_UNDO,
        ST_DONE
    } state_t;
endpackage

// File: rtl/core/two_sat_propagation_solver.sv
// One transaction in flight at a time. An unknown command is taken and ignored; an add
// reads the matrix word and writes it back with the new bit, or is dropped when a literal
// is out of range; a clear writes every matrix word to zero, one word per cycle. A solve
// clears all marks, scans matrix words, marks or undoes literals, then loads the result.
// Result register parts the channels; only a finished solve waits for m_tready.
// Reset (aresetn low, synchronous): s_tready stays low while the matrix is swept empty.
module two_sat_propagation_solver #(
    parameter int MAX_VARS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // command[1:0], from_literal[10:2], to_literal[19:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // satisfiable[0]
);
    localparam int LITS  = 2 * MAX_VARS;
    localparam int LW    = $clog2(LITS);
    localparam int RW    = (LITS + 63) / 64;
    localparam int DEPTH = LITS * RW;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = LW + 1;

    tsp_pkg::state_t state_reg, state_next;

    logic [63:0] mat_mem [DEPTH];
    logic [63:0] mat_q;
    logic        mat_we;
    logic [AW-1:0] mat_wa, mat_ra;
    logic [63:0] mat_wd;

    logic        mark_mem [LITS];
    logic        mark_q;
    logic        mark_we, mark_wd;
    logic [LW-1:0] mark_wa, mark_ra;

    logic [LW-1:0] trail_mem [LITS];
    logic [LW-1:0] trail_q;
    logic          trail_we;
    logic [LW-1:0] trail_ra;

    logic [LW-1:0] slit_mem [LITS];
    logic [LW:0]   snext_mem [LITS];
    logic [LW-1:0] slit_q;
    logic [LW:0]   snext_q;
    logic          stk_we;
    logic [LW-1:0] stk_wa;
    logic [LW-1:0] stk_wlit;
    logic [LW:0]   stk_wnext;
    logic [LW-1:0] stk_ra;

    logic [8:0]    var_count_reg;
    logic [AW:0]   cnt_reg, cnt_next;
    logic [CW-1:0] tcount_reg, tcount_next;
    logic [CW-1:0] depth_reg, depth_next;
    logic [LW:0]   v_reg, v_next;       // variable true literal
    logic          phase_reg, phase_next;
    logic [LW-1:0] lit_reg, lit_next;
    logic [LW:0]   j_reg, j_next;
    logic [LW-1:0] cand_reg, cand_next;
    logic          first_reg, first_next;
    logic          wiped_reg, wiped_next;
    logic          verdict_reg, verdict_next;
    logic          res_reg, res_next;
    logic          mv_reg, mv_next;
    logic [8:0]    from_reg, to_reg;
    logic [LW+1:0] lim;

    logic [1:0] in_cmd;
    logic [8:0] in_from, in_to;
    assign in_cmd  = s_tdata[1:0];
    assign in_from = s_tdata[10:2];
    assign in_to   = s_tdata[19:11];

    always_comb begin
        if (int'(var_count_reg) > MAX_VARS)
            lim = (LW+2)'(LITS);
        else
            lim = (LW+2)'({var_count_reg, 1'b0});
    end

    // word scan: first set bit at or after j in this word, below lim
    logic [63:0] scan_mask;
    logic        scan_hit;
    logic [5:0]  scan_bit;
    logic [LW+1:0] word_base;
    always_comb begin
        word_base = (LW+2)'(j_reg) & ~(LW+2)'(63);
        scan_hit = 1'b0;
        scan_bit = '0;
        for (int b = 0; b < 64; b++) begin
            scan_mask[b] = mat_q[b] && (6'(b) >= j_reg[5:0] || 0)
                && ((word_base + (LW+2)'(b)) < lim);
        end
        for (int b = 63; b >= 0; b--) begin
            if (scan_mask[b]) begin
                scan_hit = 1'b1;
                scan_bit = 6'(b);
            end
        end
    end

    logic accept;
    assign s_tready = (state_reg == tsp_pkg::ST_IDLE) && wiped_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {7'd0, res_reg};

    function automatic logic [AW-1:0] row_addr(input logic [LW-1:0] l, input logic [LW:0] jj);
        logic [AW+LW:0] t;
        t = (AW+LW+1)'(l) * (AW+LW+1)'(RW) + (AW+LW+1)'(jj >> 6);
        return t[AW-1:0];
    endfunction

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        tcount_next  = tcount_reg;
        depth_next   = depth_reg;
        v_next       = v_reg;
        phase_next   = phase_reg;
        lit_next     = lit_reg;
        j_next       = j_reg;
        cand_next    = cand_reg;
        first_next   = first_reg;
        wiped_next   = wiped_reg;
        verdict_next = verdict_reg;
        res_next     = res_reg;
        mv_next      = mv_reg && !m_tready;
        mat_we = 1'b0; mat_wa = '0; mat_wd = '0; mat_ra = '0;
        mark_we = 1'b0; mark_wa = '0; mark_wd = 1'b0; mark_ra = '0;
        trail_we = 1'b0; trail_ra = '0;
        stk_we = 1'b0; stk_wa = '0; stk_wlit = '0; stk_wnext = '0; stk_ra = '0;
        unique case (state_reg)
            tsp_pkg::ST_IDLE: begin
                if (!wiped_reg) begin
                    cnt_next = '0; state_next = tsp_pkg::ST_WIPE;
                end else if (accept) begin
                    priority case (tsp_pkg::cmd_t'(in_cmd))
                        tsp_pkg::CMD_CLEAR: begin
                            cnt_next = '0; state_next = tsp_pkg::ST_WIPE;
                        end
                        tsp_pkg::CMD_ADD: state_next = tsp_pkg::ST_ADD_RD;
                        tsp_pkg::CMD_SOLVE: begin
                            cnt_next = '0; state_next = tsp_pkg::ST_MCLR;
                        end
                        default: ;
                    endcase
                end
            end
            tsp_pkg::ST_WIPE: begin
                mat_we = 1'b1; mat_wa = cnt_reg[AW-1:0]; mat_wd = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(DEPTH - 1)) begin
                    wiped_next = 1'b1; state_next = tsp_pkg::ST_IDLE;
                end
            end
            tsp_pkg::ST_ADD_RD: begin
                mat_ra = row_addr(LW'(from_reg), (LW+1)'(to_reg));
                if (32'(from_reg) < 32'(lim) && 32'(to_reg) < 32'(lim))
                    state_next = tsp_pkg::ST_ADD_WR;
                else
                    state_next = tsp_pkg::ST_IDLE;
            end
            tsp_pkg::ST_ADD_WR: begin
                mat_we = 1'b1;
                mat_wa = row_addr(LW'(from_reg), (LW+1)'(to_reg));
                mat_wd = mat_q | (64'd1 << to_reg[5:0]);
                state_next = tsp_pkg::ST_IDLE;
            end
            tsp_pkg::ST_MCLR: begin
                mark_we = 1'b1; mark_wa = cnt_reg[LW-1:0]; mark_wd = 1'b0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(LITS - 1)) begin
                    v_next = '0; state_next = tsp_pkg::ST_VAR;
                end
            end
            tsp_pkg::ST_VAR: begin
                if ((LW+2)'(v_reg) >= lim) begin
                    verdict_next = 1'b1; state_next = tsp_pkg::ST_DONE;
                end else begin
                    mark_ra = v_reg[LW-1:0];
                    cand_next = v_reg[LW-1:0] | LW'(1);
                    state_next = tsp_pkg::ST_VAR_RD;
                    first_next = 1'b1;
                end
            end
            tsp_pkg::ST_VAR_RD: begin
                // first step: mark of true literal; second: of false literal
                if (first_reg) begin
                    mark_ra = cand_reg; first_next = 1'b0;
                    j_next = {LW'(0), mark_q};
                end else if (j_reg[0] || mark_q) begin
                    v_next = v_reg + (LW+1)'(2); state_next = tsp_pkg::ST_VAR;
                end else begin
                    tcount_next = '0; phase_next = 1'b0;
                    lit_next = v_reg[LW-1:0];
                    state_next = tsp_pkg::ST_ROOT;
                end
            end
            tsp_pkg::ST_ROOT: begin
                // root unmarked with both literals clear: mark and push
                mark_we = 1'b1; mark_wa = lit_reg; mark_wd = 1'b1;
                trail_we = 1'b1;
                tcount_next = tcount_reg + 1'b1;
                stk_we = 1'b1; stk_wa = '0; stk_wlit = lit_reg; stk_wnext = '0;
                depth_next = CW'(1);
                state_next = tsp_pkg::ST_TOP_RD;
            end
            tsp_pkg::ST_TOP_RD: begin
                if (depth_reg == '0) begin
                    v_next = v_reg + (LW+1)'(2); state_next = tsp_pkg::ST_VAR;
                end else begin
                    stk_ra = LW'(depth_reg - 1'b1);
                    first_next = 1'b1;
                    state_next = tsp_pkg::ST_ROW_RD;
                end
            end
            tsp_pkg::ST_ROW_RD: begin
                if (first_reg) begin
                    lit_next = slit_q; j_next = snext_q;
                    first_next = 1'b0;
                    mat_ra = row_addr(slit_q, snext_q);
                    if ((LW+2)'(snext_q) >= lim) begin
                        depth_next = depth_reg - 1'b1;
                        state_next = tsp_pkg::ST_TOP_RD;
                    end else state_next = tsp_pkg::ST_ROW_SCAN;
                end
            end
            tsp_pkg::ST_ROW_SCAN: begin
                if (scan_hit) begin
                    cand_next = LW'(word_base) | LW'(scan_bit);
                    stk_we = 1'b1; stk_wa = LW'(depth_reg - 1'b1); stk_wlit = lit_reg;
                    stk_wnext = (LW+1)'(LW'(word_base) | LW'(scan_bit)) + 1'b1;
                    mark_ra = (LW'(word_base) | LW'(scan_bit)) ^ LW'(1);
                    first_next = 1'b1;
                    state_next = tsp_pkg::ST_CHK_RD;
                end else if ((word_base + (LW+2)'(64)) >= lim) begin
                    depth_next = depth_reg - 1'b1;
                    state_next = tsp_pkg::ST_TOP_RD;
                end else begin
                    j_next = (LW+1)'(word_base + (LW+2)'(64));
                    mat_ra = row_addr(lit_reg, (LW+1)'(word_base + (LW+2)'(64)));
                end
            end
            tsp_pkg::ST_CHK_RD: begin
                mark_ra = cand_reg;
                state_next = tsp_pkg::ST_CHK;
                j_next = {LW'(0), mark_q};   // complement mark
            end
            tsp_pkg::ST_CHK: begin
                if (j_reg[0]) begin
                    depth_next = '0;
                    if (phase_reg) begin
                        verdict_next = 1'b0; state_next = tsp_pkg::ST_DONE;
                    end else state_next = tsp_pkg::ST_UNDO_RD;
                end else if (mark_q) begin
                    state_next = tsp_pkg::ST_TOP_RD;
                end else begin
                    mark_we = 1'b1; mark_wa = cand_reg; mark_wd = 1'b1;
                    trail_we = (tcount_reg < CW'(LITS));
                    if (tcount_reg < CW'(LITS)) tcount_next = tcount_reg + 1'b1;
                    if (depth_reg < CW'(LITS)) begin
                        stk_we = 1'b1; stk_wa = LW'(depth_reg); stk_wlit = cand_reg;
                        stk_wnext = '0; depth_next = depth_reg + 1'b1;
                    end
                    state_next = tsp_pkg::ST_TOP_RD;
                end
            end
            tsp_pkg::ST_UNDO_RD: begin
                if (tcount_reg == '0) begin
                    phase_next = 1'b1;
                    lit_next = v_reg[LW-1:0] | LW'(1);
                    state_next = tsp_pkg::ST_ROOT;
                end else begin
                    trail_ra = LW'(tcount_reg - 1'b1);
                    tcount_next = tcount_reg - 1'b1;
                    state_next = tsp_pkg::ST_UNDO;
                end
            end
            tsp_pkg::ST_UNDO: begin
                mark_we = 1'b1; mark_wa = trail_q; mark_wd = 1'b0;
                state_next = tsp_pkg::ST_UNDO_RD;
            end
            tsp_pkg::ST_DONE: begin
                // hold the verdict until the output register is free
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1; res_next = verdict_reg;
                    state_next = tsp_pkg::ST_IDLE;
                end
            end
            default: state_next = tsp_pkg::ST_IDLE;
        endcase
    end

    // trail write address follows the pre-update count
    logic [LW-1:0] trail_wa, trail_wd;
    assign trail_wa = LW'(tcount_reg);
    assign trail_wd = (state_reg == tsp_pkg::ST_ROOT) ? lit_reg : cand_reg;

    always_ff @(posedge aclk) begin
        if (mat_we) mat_mem[mat_wa] <= mat_wd;
        mat_q <= mat_mem[mat_ra];
        if (mark_we) mark_mem[mark_wa] <= mark_wd;
        mark_q <= mark_mem[mark_ra];
        if (trail_we) trail_mem[trail_wa] <= trail_wd;
        trail_q <= trail_mem[trail_ra];
        if (stk_we) begin
            slit_mem[stk_wa]  <= stk_wlit;
            snext_mem[stk_wa] <= stk_wnext;
        end
        slit_q  <= slit_mem[stk_ra];
        snext_q <= snext_mem[stk_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tsp_pkg::ST_IDLE;
            var_count_reg <= 9'd256;
            cnt_reg <= '0; tcount_reg <= '0; depth_reg <= '0;
            v_reg <= '0; phase_reg <= 1'b0; first_reg <= 1'b0;
            wiped_reg <= 1'b0; mv_reg <= 1'b0; res_reg <= 1'b0;
            verdict_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) var_count_reg <= cfg_wr_data;
            cnt_reg <= cnt_next; tcount_reg <= tcount_next; depth_reg <= depth_next;
            v_reg <= v_next; phase_reg <= phase_next; first_reg <= first_next;
            wiped_reg <= wiped_next; mv_reg <= mv_next; res_reg <= res_next;
            verdict_reg <= verdict_next;
        end
    end

    always_ff @(posedge aclk) begin
        lit_reg  <= lit_next;
        j_reg    <= j_next;
        cand_reg <= cand_next;
        if (accept) begin
            from_reg <= in_from;
            to_reg   <= in_to;
        end
    end
endmodule

// File: rtl/core/tsp_checker.sv
`include "two_sat_propagation_solver_macros.svh"
module tsp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tcmd,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    `TSP_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TSP_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[7:1] == 7'd0)
    `TSP_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_tvalid && s_tready && s_tcmd != tsp_pkg::CMD_NONE, !s_tready)
endmodule

bind two_sat_propagation_solver tsp_checker u_tsp_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tcmd(s_tdata[1:0]),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// File: dv/two_sat_propagation_solver_tb.sv
`timescale 1ns / 100ps

module two_sat_propagation_solver_tb;
    localparam int MAX_VARS = 256;
    localparam int LITS = 2 * MAX_VARS;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [8:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // command[1:0], from_literal[10:2], to_literal[19:11]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // satisfiable[0]

    two_sat_propagation_solver #(.MAX_VARS(MAX_VARS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state
    bit       graph [LITS][LITS];
    bit       marked [LITS];
    int       trail_buf [LITS];
    int       trail_len;
    bit [8:0] var_cfg;

    bit       sat_expected [$];
    int       fail_count;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_off;

    typedef struct {
        tsp_pkg::cmd_t op;
        bit [8:0]      src;
        bit [8:0]      dst;
        int            sat;   // -1: from predictor only
    } row_t;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #1s;
        $display("status: fail");
        $finish;
    end

    function automatic bit reach_from(int root, int lim);
        int lit_stk [LITS];
        int nxt_stk [LITS];
        int top;
        int lit;
        int j;
        if (marked[root ^ 1]) return 1'b0;
        if (marked[root]) return 1'b1;
        marked[root] = 1'b1;
        trail_buf[trail_len] = root;
        trail_len++;
        lit_stk[0] = root;
        nxt_stk[0] = 0;
        top = 1;
        while (top > 0) begin
            lit = lit_stk[top - 1];
            j = nxt_stk[top - 1];
            while (j < lim && !graph[lit][j]) j++;
            if (j >= lim) begin
                top--;
                continue;
            end
            nxt_stk[top - 1] = j + 1;
            if (marked[j ^ 1]) return 1'b0;
            if (marked[j]) continue;
            marked[j] = 1'b1;
            trail_buf[trail_len] = j;
            trail_len++;
            lit_stk[top] = j;
            nxt_stk[top] = 0;
            top++;
        end
        return 1'b1;
    endfunction

    function automatic int lit_limit();
        return 2 * ((var_cfg > MAX_VARS) ? MAX_VARS : int'(var_cfg));
    endfunction

    function automatic bit decide_sat();
        int lim;
        lim = lit_limit();
        foreach (marked[i]) marked[i] = 1'b0;
        for (int v = 0; v < lim; v += 2) begin
            if (marked[v] || marked[v + 1]) continue;
            trail_len = 0;
            if (!reach_from(v, lim)) begin
                while (trail_len > 0) begin
                    trail_len--;
                    marked[trail_buf[trail_len]] = 1'b0;
                end
                if (!reach_from(v + 1, lim)) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void apply_cmd(tsp_pkg::cmd_t op, bit [8:0] src, bit [8:0] dst,
                                      int sat);
        bit r;
        case (op)
            tsp_pkg::CMD_CLEAR: begin
                foreach (graph[a, b]) graph[a][b] = 1'b0;
            end
            tsp_pkg::CMD_ADD: begin
                if (src < lit_limit() && dst < lit_limit()) graph[src][dst] = 1'b1;
            end
            tsp_pkg::CMD_SOLVE: begin
                r = decide_sat();
                if (sat >= 0 && r != sat[0]) begin
                    $display("predictor disagrees with table: sat %0d", sat);
                    fail_count++;
                end
                sat_expected = {sat_expected, r};
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // leaves s_tvalid high after the accepting edge; the caller drops it
    task automatic send_cmd(tsp_pkg::cmd_t op, bit [8:0] src, bit [8:0] dst, int sat);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, dst, src, op};
        do @(posedge aclk); while (!s_tready);
        apply_cmd(op, src, dst, sat);
    endtask

    task automatic wait_drained();
        int n;
        s_tvalid <= 1'b0;
        n = 0;
        while (sat_expected.size() > 0 && n < 5000000) begin
            @(posedge aclk);
            n++;
        end
        // a clear may still be sweeping
        repeat (2 * MAX_VARS * 8 + 50) @(posedge aclk);
    endtask

    task automatic write_vars(bit [8:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        var_cfg = v;
    endtask

    // receiver
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (sat_expected.size() == 0) begin
                report_mismatch("unexpected transaction", int'(m_tdata), -1);
            end else begin
                if (m_tdata[0] != sat_expected[0])
                    report_mismatch("satisfiable", int'(m_tdata[0]), int'(sat_expected[0]));
                void'(sat_expected.pop_front());
            end
        end
        m_tready <= !hold_off && !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    // random formula over nv variables, solved a few times
    task automatic random_formula(int n_edges);
        int nv;
        int lits;
        nv = (var_cfg == 0) ? 1 : ((var_cfg > 16) ? 16 : int'(var_cfg));
        lits = 2 * nv;
        send_cmd(tsp_pkg::CMD_CLEAR, 9'($urandom), 9'($urandom), -1);
        for (int i = 0; i < n_edges; i++) begin
            if ($urandom_range(19) == 0)
                send_cmd(tsp_pkg::cmd_t'($urandom_range(3)), 9'($urandom), 9'($urandom), -1);
            else
                send_cmd(tsp_pkg::CMD_ADD, 9'($urandom_range(lits - 1)),
                         9'($urandom_range(lits - 1)), -1);
            if ($urandom_range(5) == 0)
                send_cmd(tsp_pkg::CMD_SOLVE, 9'($urandom), 9'($urandom), -1);
        end
        send_cmd(tsp_pkg::CMD_SOLVE, 9'($urandom), 9'($urandom), -1);
    endtask

    row_t directed [$];
    int sent;

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        hold_off = 1'b0;
        fail_count = 0;
        trail_len = 0;
        var_cfg = 9'd256;
        send_idle_pct = 27;
        recv_idle_pct = 83;
        foreach (graph[a, b]) graph[a][b] = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty graph at full width is satisfiable, then contradictions and clears
        directed = '{
            '{tsp_pkg::CMD_SOLVE, 9'd0,   9'd0,   1},
            '{tsp_pkg::CMD_ADD,   9'd0,   9'd1,   -1},
            '{tsp_pkg::CMD_ADD,   9'd1,   9'd0,   -1},
            '{tsp_pkg::CMD_SOLVE, 9'd0,   9'd0,   0},
            '{tsp_pkg::CMD_ADD,   9'd0,   9'd1,   -1},
            '{tsp_pkg::CMD_NONE,  9'd511, 9'd511, -1},
            '{tsp_pkg::CMD_SOLVE, 9'd0,   9'd0,   0},
            '{tsp_pkg::CMD_CLEAR, 9'd511, 9'd511, -1},
            '{tsp_pkg::CMD_SOLVE, 9'd0,   9'd0,   1},
            '{tsp_pkg::CMD_ADD,   9'd511, 9'd510, -1},
            '{tsp_pkg::CMD_ADD,   9'd510, 9'd511, -1},
            '{tsp_pkg::CMD_SOLVE, 9'd0,   9'd0,   0},
            '{tsp_pkg::CMD_CLEAR, 9'd0,   9'd0,   -1},
            '{tsp_pkg::CMD_ADD,   9'd0,   9'd3,   -1},
            '{tsp_pkg::CMD_ADD,   9'd3,   9'd1,   -1},
            '{tsp_pkg::CMD_ADD,   9'd2,   9'd5,   -1},
            '{tsp_pkg::CMD_SOLVE, 9'd0,   9'd0,   -1}
        };
        foreach (directed[i])
            send_cmd(directed[i].op, directed[i].src, directed[i].dst, directed[i].sat);
        wait_drained();

        // stale edges: shrink so 510/511 are out of range
        write_vars(9'd4);
        send_cmd(tsp_pkg::CMD_ADD, 9'd511, 9'd0, -1);
        send_cmd(tsp_pkg::CMD_ADD, 9'd0, 9'd8, -1);
        send_cmd(tsp_pkg::CMD_SOLVE, 9'd0, 9'd0, 1);
        wait_drained();
        write_vars(9'd0);
        send_cmd(tsp_pkg::CMD_ADD, 9'd0, 9'd1, -1);
        send_cmd(tsp_pkg::CMD_SOLVE, 9'd0, 9'd0, 1);
        wait_drained();
        write_vars(9'd511);
        send_cmd(tsp_pkg::CMD_SOLVE, 9'd0, 9'd0, 1);
        wait_drained();

        // long stall on the receiver while solves pile up
        write_vars(9'd1);
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 6; i++)
                    send_cmd(tsp_pkg::CMD_SOLVE, 9'd0, 9'd0, -1);
                s_tvalid <= 1'b0;
            end
        join
        wait_drained();

        sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 83;
                recv_idle_pct = 27;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int k = 0; k < 12; k++) begin
                case ($urandom_range(5))
                    0: write_vars(9'd1);
                    1: write_vars(9'd2);
                    2: write_vars(9'd256);
                    3: write_vars(9'($urandom));
                    default: write_vars(9'($urandom_range(3, 16)));
                endcase
                random_formula($urandom_range(10, 54));
                wait_drained();
            end
        end

        wait_drained();
        if (fail_count == 0 && sat_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
